/* rtl/tsre_pkg.sv */
// Shared types and constants for the TCP sender retransmit engine.
package tsre_pkg;

    localparam int MAX_RESULTS = 64;
    localparam int RES_AW      = 6;
    localparam int ENT_W       = 45;
    localparam int RES_W       = 46;
    localparam int IN_DATA_W   = 88;
    localparam int OUT_DATA_W  = 96;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [2:0] {
        FN_WRITE = 3'd0,
        FN_ACK   = 3'd1,
        FN_TICK  = 3'd2,
        FN_FILL  = 3'd3,
        FN_EMPTY = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        CFG_ISEQ = 2'd0,
        CFG_ITO  = 2'd1,
        CFG_MSP  = 2'd2,
        CFG_CAP  = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_ACK_CHK,
        ST_ACK_RD,
        ST_ACK_EVAL,
        ST_ACK_END,
        ST_FILL,
        ST_FILL_LOOP,
        ST_FILL_END,
        ST_TICK,
        ST_TICK_EMIT,
        ST_EMPTY,
        ST_PLAY_RD,
        ST_PLAY_LD
    } state_t;

endpackage

/* rtl/tsre_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tsre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/tcp_sender_retransmit_engine.sv */
// TCP sender sliding-window engine: segment headers, acks, timer and retransmission.
// One item is taken at a time; s_tready is high only while the engine is idle. A write
// item updates the send buffer and then plays out its results; an empty-segment item records
// one result, and a tick item records a retransmission only when the timer fires. An ack
// that is stale or beyond the next sequence number goes straight to play-out; otherwise the
// outstanding entries are read and examined in turn from the head, followed by the fill
// steps. A fill sends the lone SYN if it has not been sent, otherwise it emits segments one
// by one in its loop. The result store then plays out each result in turn, stalling while
// m_tready is low. The outstanding-segment table is a RAM read one entry at a time during ack processing.
module tcp_sender_retransmit_engine import tsre_pkg::*; #(
    parameter int OUTSTANDING_DEPTH = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // byte_count, end_input, ack_number, advertised_window, elapsed_ms, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // func
    input  logic [2:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // has_segment, seg_seqno, seg_payload_len, seg_syn, seg_fin, is_retransmission,
    // bytes_accepted, in_flight_bytes, retransmit_count
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int IW = $clog2(OUTSTANDING_DEPTH);
    localparam int CW = $clog2(OUTSTANDING_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(OUTSTANDING_DEPTH);
    localparam logic [IW:0]   DEPTH_S = (IW+1)'(OUTSTANDING_DEPTH);
    localparam logic [IW-1:0] HEAD_LAST = IW'(OUTSTANDING_DEPTH - 1);
    localparam logic [6:0]    MAX_RES_C = 7'(MAX_RESULTS);

    state_t state_reg, state_next;

    logic [15:0] cnt_reg, cnt_next;
    logic        end_reg, end_next;
    logic [31:0] ackno_reg, ackno_next;
    logic [15:0] win_reg, win_next;
    logic [15:0] ms_reg, ms_next;

    logic [31:0] iseq_reg, iseq_next;
    logic [15:0] ito_reg, ito_next;
    logic [10:0] msp_reg, msp_next;
    logic [15:0] cap_reg, cap_next;

    logic [15:0] buf_reg, buf_next;
    logic        ended_reg, ended_next;
    logic        syn_sent_reg, syn_sent_next;
    logic        fin_sent_reg, fin_sent_next;
    logic [31:0] pos_reg, pos_next;
    logic [16:0] flight_reg, flight_next;
    logic [15:0] peer_win_reg, peer_win_next;
    logic [31:0] lacked_reg, lacked_next;
    logic        lacked_vld_reg, lacked_vld_next;
    logic [31:0] timer_reg, timer_next;
    logic        running_reg, running_next;
    logic [31:0] cur_to_reg, cur_to_next;
    logic [15:0] resend_reg, resend_next;
    logic [IW-1:0] head_reg, head_next;
    logic [CW-1:0] used_reg, used_next;
    logic [15:0] room_reg, room_next;
    logic [6:0]  nres_reg, nres_next;
    logic [5:0]  pidx_reg, pidx_next;
    logic [15:0] acc_reg, acc_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                  m_tlast_reg, m_tlast_next;

    logic             ent_we, ent_re;
    logic [IW-1:0]    ent_waddr, ent_raddr;
    logic [ENT_W-1:0] ent_wdata, ent_rdata;
    logic             res_we, res_re;
    logic [RES_W-1:0] res_wdata, res_rdata;

    logic        in_acc;
    logic [31:0] cur_seq;
    logic        ack_beyond, ack_stale;
    logic [31:0] e_seq;
    logic [10:0] e_len;
    logic        e_syn, e_fin;
    logic [11:0] e_total;
    logic        covered, fresh, partial;
    logic [31:0] d1, d2, xoff, sub, lacked_new;
    logic [11:0] rem;
    logic [16:0] flight_after_sub;
    logic [15:0] win_eff, room_init;
    logic        fill_go, seg_fin, len_zero;
    logic [15:0] take1, take, buf_after;
    logic [11:0] seg_len;
    logic [17:0] flight_sum;
    logic [16:0] flight_after_add;
    logic [32:0] tsum;
    logic [31:0] tsat;
    logic        tick_fire;
    logic [IW:0] tail_sum;
    logic [IW-1:0] tail;
    logic [IW-1:0] head_inc;
    logic [15:0] space;
    logic        out_free, play_last;

    tsre_ram #(.WIDTH(ENT_W), .DEPTH(OUTSTANDING_DEPTH)) u_ent_ram (
        .aclk  (aclk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    tsre_ram #(.WIDTH(RES_W), .DEPTH(MAX_RESULTS)) u_res_ram (
        .aclk  (aclk),
        .we    (res_we),
        .waddr (nres_reg[RES_AW-1:0]),
        .wdata (res_wdata),
        .re    (res_re),
        .raddr (pidx_reg),
        .rdata (res_rdata)
    );

    assign in_acc  = s_tvalid && s_tready;
    assign cur_seq = iseq_reg + pos_reg;

    assign ack_beyond = ackno_reg > cur_seq;
    assign ack_stale  = lacked_vld_reg && (ackno_reg <= lacked_reg);

    assign e_seq   = ent_rdata[31:0];
    assign e_len   = ent_rdata[42:32];
    assign e_syn   = ent_rdata[43];
    assign e_fin   = ent_rdata[44];
    assign e_total = {1'b0, e_len} + {11'd0, e_syn} + {11'd0, e_fin};
    assign covered = e_seq < ackno_reg;
    assign fresh   = !lacked_vld_reg || (lacked_reg <= e_seq);
    assign d1      = ackno_reg - e_seq;
    assign d2      = ackno_reg - lacked_reg;
    assign xoff    = lacked_reg - e_seq;
    assign rem     = e_total - xoff[11:0];

    always_comb begin
        if (fresh) begin
            partial = {20'd0, e_total} > d1;
            sub     = partial ? d1 : {20'd0, e_total};
        end else begin
            partial = (xoff > {20'd0, e_total}) || ({20'd0, rem} > d2);
            sub     = partial ? d2 : {20'd0, rem};
        end
    end

    assign flight_after_sub = (sub >= {15'd0, flight_reg}) ? 17'd0 : flight_reg - sub[16:0];
    assign lacked_new       = partial ? ackno_reg : e_seq + {20'd0, e_total};

    assign win_eff   = (peer_win_reg == 16'd0) ? 16'd1 : peer_win_reg;
    assign room_init = ({1'b0, win_eff} > flight_reg) ? 16'({1'b0, win_eff} - flight_reg)
                                                      : 16'd0;

    assign fill_go   = (room_reg != 16'd0) && !fin_sent_reg && (nres_reg < MAX_RES_C)
                       && (used_reg < DEPTH_C);
    assign take1     = (room_reg < {5'd0, msp_reg}) ? room_reg : {5'd0, msp_reg};
    assign take      = (take1 > buf_reg) ? buf_reg : take1;
    assign buf_after = buf_reg - take;
    assign seg_fin   = ended_reg && (buf_after == 16'd0) && (room_reg > take);
    assign seg_len   = take[11:0] + {11'd0, seg_fin};
    assign len_zero  = seg_len == 12'd0;

    always_comb begin
        flight_sum = {1'b0, flight_reg};
        case (state_reg)
            ST_FILL:      flight_sum = {1'b0, flight_reg} + 18'd1;
            ST_FILL_LOOP: flight_sum = {1'b0, flight_reg} + {6'd0, seg_len};
            default:      flight_sum = {1'b0, flight_reg};
        endcase
    end
    assign flight_after_add = flight_sum[17] ? 17'h1FFFF : flight_sum[16:0];

    assign tsum      = {1'b0, timer_reg} + {17'd0, ms_reg};
    assign tsat      = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
    assign tick_fire = (used_reg != '0) && (tsat >= cur_to_reg);

    assign tail_sum = {1'b0, head_reg} + (IW+1)'(used_reg);
    assign tail     = (tail_sum >= DEPTH_S) ? IW'(tail_sum - DEPTH_S) : tail_sum[IW-1:0];
    assign head_inc = (head_reg == HEAD_LAST) ? '0 : head_reg + 1'b1;

    assign space     = (cap_reg > buf_reg) ? cap_reg - buf_reg : 16'd0;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign play_last = (nres_reg == 7'd0) || ({1'b0, pidx_reg} == nres_reg - 7'd1);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    case (s_tuser)
                        FN_WRITE: state_next = ST_WRITE;
                        FN_ACK:   state_next = ST_ACK_CHK;
                        FN_TICK:  state_next = ST_TICK;
                        FN_FILL:  state_next = ST_FILL;
                        FN_EMPTY: state_next = ST_EMPTY;
                        default:  state_next = ST_PLAY_RD;
                    endcase
                end
            end
            ST_WRITE:   state_next = ST_PLAY_RD;
            ST_ACK_CHK: begin
                if (ack_beyond || ack_stale) begin
                    state_next = ST_PLAY_RD;
                end else if (used_reg == '0) begin
                    state_next = ST_ACK_END;
                end else begin
                    state_next = ST_ACK_RD;
                end
            end
            ST_ACK_RD:  state_next = ST_ACK_EVAL;
            ST_ACK_EVAL: begin
                if (!covered || partial || used_reg == CW'(1)) begin
                    state_next = ST_ACK_END;
                end else begin
                    state_next = ST_ACK_RD;
                end
            end
            ST_ACK_END: state_next = ST_FILL;
            ST_FILL:    state_next = syn_sent_reg ? ST_FILL_LOOP : ST_PLAY_RD;
            ST_FILL_LOOP: begin
                if (!fill_go || len_zero) begin
                    state_next = ST_FILL_END;
                end
            end
            ST_FILL_END: state_next = ST_PLAY_RD;
            ST_TICK: begin
                if (running_reg && tick_fire) begin
                    state_next = ST_TICK_EMIT;
                end else begin
                    state_next = ST_PLAY_RD;
                end
            end
            ST_TICK_EMIT: state_next = ST_PLAY_RD;
            ST_EMPTY:     state_next = ST_PLAY_RD;
            ST_PLAY_RD:   state_next = ST_PLAY_LD;
            ST_PLAY_LD: begin
                if (out_free) begin
                    state_next = play_last ? ST_IDLE : ST_PLAY_RD;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        cnt_next        = cnt_reg;
        end_next        = end_reg;
        ackno_next      = ackno_reg;
        win_next        = win_reg;
        ms_next         = ms_reg;
        iseq_next       = iseq_reg;
        ito_next        = ito_reg;
        msp_next        = msp_reg;
        cap_next        = cap_reg;
        buf_next        = buf_reg;
        ended_next      = ended_reg;
        syn_sent_next   = syn_sent_reg;
        fin_sent_next   = fin_sent_reg;
        pos_next        = pos_reg;
        flight_next     = flight_reg;
        peer_win_next   = peer_win_reg;
        lacked_next     = lacked_reg;
        lacked_vld_next = lacked_vld_reg;
        timer_next      = timer_reg;
        running_next    = running_reg;
        cur_to_next     = cur_to_reg;
        resend_next     = resend_reg;
        head_next       = head_reg;
        used_next       = used_reg;
        room_next       = room_reg;
        nres_next       = nres_reg;
        pidx_next       = pidx_reg;
        acc_next        = acc_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tlast_next    = m_tlast_reg;
        ent_we          = 1'b0;
        ent_waddr       = tail;
        ent_wdata       = '0;
        ent_re          = 1'b0;
        ent_raddr       = head_reg;
        res_we          = 1'b0;
        res_wdata       = '0;
        res_re          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (cfg_we) begin
                    case (cfg_index)
                        CFG_ISEQ: iseq_next = cfg_wdata;
                        CFG_ITO: begin
                            ito_next    = cfg_wdata[15:0];
                            cur_to_next = {16'd0, cfg_wdata[15:0]};
                        end
                        CFG_MSP:  msp_next = cfg_wdata[10:0];
                        CFG_CAP:  cap_next = cfg_wdata[15:0];
                        default:  iseq_next = iseq_reg;
                    endcase
                end
                if (in_acc) begin
                    cnt_next   = s_tdata[15:0];
                    end_next   = s_tdata[16];
                    ackno_next = s_tdata[48:17];
                    win_next   = s_tdata[64:49];
                    ms_next    = s_tdata[80:65];
                    nres_next  = 7'd0;
                    pidx_next  = 6'd0;
                    acc_next   = 16'd0;
                end
            end
            ST_WRITE: begin
                if (!ended_reg) begin
                    acc_next = (cnt_reg < space) ? cnt_reg : space;
                    buf_next = buf_reg + ((cnt_reg < space) ? cnt_reg : space);
                end
                if (end_reg) begin
                    ended_next = 1'b1;
                end
            end
            ST_ACK_CHK: begin
                if (!ack_beyond && ack_stale) begin
                    peer_win_next = win_reg;
                end
            end
            ST_ACK_RD: begin
                ent_re = 1'b1;
            end
            ST_ACK_EVAL: begin
                if (covered) begin
                    timer_next      = 32'd0;
                    cur_to_next     = {16'd0, ito_reg};
                    flight_next     = flight_after_sub;
                    lacked_next     = lacked_new;
                    lacked_vld_next = 1'b1;
                    if (!partial) begin
                        head_next = head_inc;
                        used_next = used_reg - 1'b1;
                    end
                end
            end
            ST_ACK_END: begin
                if (used_reg == '0) begin
                    running_next = 1'b0;
                end
                resend_next   = 16'd0;
                peer_win_next = win_reg;
            end
            ST_FILL: begin
                if (!syn_sent_reg) begin
                    syn_sent_next = 1'b1;
                    pos_next      = pos_reg + 32'd1;
                    flight_next   = flight_after_add;
                    res_we        = 1'b1;
                    res_wdata     = {1'b0, 1'b0, 1'b1, 11'd0, cur_seq};
                    nres_next     = nres_reg + 7'd1;
                    if (used_reg < DEPTH_C) begin
                        ent_we    = 1'b1;
                        ent_wdata = {1'b0, 1'b1, 11'd0, cur_seq};
                        used_next = used_reg + 1'b1;
                    end
                    running_next = 1'b1;
                end else begin
                    room_next = room_init;
                end
            end
            ST_FILL_LOOP: begin
                if (fill_go) begin
                    buf_next    = buf_after;
                    pos_next    = pos_reg + {20'd0, seg_len};
                    flight_next = flight_after_add;
                    room_next   = room_reg - {4'd0, seg_len};
                    if (seg_fin) begin
                        fin_sent_next = 1'b1;
                    end
                    if (!len_zero) begin
                        if (used_reg == '0) begin
                            timer_next = 32'd0;
                        end
                        res_we       = 1'b1;
                        res_wdata    = {1'b0, seg_fin, 1'b0, take[10:0], cur_seq};
                        nres_next    = nres_reg + 7'd1;
                        ent_we       = 1'b1;
                        ent_wdata    = {seg_fin, 1'b0, take[10:0], cur_seq};
                        used_next    = used_reg + 1'b1;
                        running_next = 1'b1;
                    end
                end
            end
            ST_FILL_END: begin
                if (used_reg == '0) begin
                    running_next = 1'b0;
                    timer_next   = 32'd0;
                end
            end
            ST_TICK: begin
                if (running_reg) begin
                    timer_next = tsat;
                    if (tick_fire) begin
                        timer_next = 32'd0;
                        ent_re     = 1'b1;
                    end
                end
            end
            ST_TICK_EMIT: begin
                res_we    = 1'b1;
                res_wdata = {1'b1, e_fin, e_syn, e_len, e_seq};
                nres_next = nres_reg + 7'd1;
                if (peer_win_reg != 16'd0) begin
                    cur_to_next = cur_to_reg[31] ? 32'hFFFF_FFFF : {cur_to_reg[30:0], 1'b0};
                    if (resend_reg != 16'hFFFF) begin
                        resend_next = resend_reg + 16'd1;
                    end
                end
            end
            ST_EMPTY: begin
                res_we    = 1'b1;
                res_wdata = {1'b0, 1'b0, 1'b0, 11'd0, cur_seq};
                nres_next = nres_reg + 7'd1;
            end
            ST_PLAY_RD: begin
                res_re = nres_reg != 7'd0;
            end
            ST_PLAY_LD: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = play_last;
                    if (nres_reg == 7'd0) begin
                        m_tdata_next = {resend_reg, flight_reg, acc_reg, 47'd0};
                    end else begin
                        m_tdata_next = {resend_reg, flight_reg, acc_reg,
                                        res_rdata[45], res_rdata[44], res_rdata[43],
                                        res_rdata[42:32], res_rdata[31:0], 1'b1};
                    end
                    pidx_next = pidx_reg + 6'd1;
                end
            end
            default: begin
                nres_next = nres_reg;
            end
        endcase
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            iseq_reg       <= 32'd0;
            ito_reg        <= 16'd1000;
            msp_reg        <= 11'd1000;
            cap_reg        <= 16'd64000;
            buf_reg        <= 16'd0;
            ended_reg      <= 1'b0;
            syn_sent_reg   <= 1'b0;
            fin_sent_reg   <= 1'b0;
            pos_reg        <= 32'd0;
            flight_reg     <= 17'd0;
            peer_win_reg   <= 16'd1;
            lacked_reg     <= 32'd0;
            lacked_vld_reg <= 1'b0;
            timer_reg      <= 32'd0;
            running_reg    <= 1'b0;
            cur_to_reg     <= 32'd1000;
            resend_reg     <= 16'd0;
            head_reg       <= '0;
            used_reg       <= '0;
            nres_reg       <= 7'd0;
            pidx_reg       <= 6'd0;
            acc_reg        <= 16'd0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            iseq_reg       <= iseq_next;
            ito_reg        <= ito_next;
            msp_reg        <= msp_next;
            cap_reg        <= cap_next;
            buf_reg        <= buf_next;
            ended_reg      <= ended_next;
            syn_sent_reg   <= syn_sent_next;
            fin_sent_reg   <= fin_sent_next;
            pos_reg        <= pos_next;
            flight_reg     <= flight_next;
            peer_win_reg   <= peer_win_next;
            lacked_reg     <= lacked_next;
            lacked_vld_reg <= lacked_vld_next;
            timer_reg      <= timer_next;
            running_reg    <= running_next;
            cur_to_reg     <= cur_to_next;
            resend_reg     <= resend_next;
            head_reg       <= head_next;
            used_reg       <= used_next;
            nres_reg       <= nres_next;
            pidx_reg       <= pidx_next;
            acc_reg        <= acc_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg     <= cnt_next;
        end_reg     <= end_next;
        ackno_reg   <= ackno_next;
        win_reg     <= win_next;
        ms_reg      <= ms_next;
        room_reg    <= room_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

`ifndef NO_ASSERTIONS
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= DEPTH_C)
        else $error("outstanding count over depth");
    a_nres_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nres_reg <= MAX_RES_C)
        else $error("result count over limit");
    a_busy_after: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_tready)
        else $error("item accepted while busy");
    a_fin_ended: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_sent_reg |-> ended_reg)
        else $error("FIN sent before stream end");
`endif

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the TCP sender retransmit engine: predicts segment results.
`timescale 1ns / 100ps

module tb_top;
    import tsre_pkg::*;

    localparam int DEPTH     = 64;
    localparam int CYCLE_CAP = 4000000;

    typedef struct {
        logic [2:0]  func;
        logic [15:0] byte_count;
        logic        end_input;
        logic [31:0] ack_number;
        logic [15:0] adv_window;
        logic [15:0] elapsed_ms;
    } seg_req_t;

    typedef struct packed {
        bit        has_seg;
        bit [31:0] seqno;
        bit [10:0] payload;
        bit        syn;
        bit        fin;
        bit        rtx;
        bit [15:0] accepted;
        bit [16:0] in_flight;
        bit [15:0] rtx_count;
        bit        last;
    } seg_res_t;

    class sender_scoreboard;
        bit [31:0] iseq;
        bit [31:0] ito;
        bit [31:0] msp;
        bit [31:0] cap;
        bit [31:0] buffered;
        bit        ended, syn_sent, fin_sent;
        bit [31:0] next_pos;
        bit [31:0] flight;
        bit [31:0] peer_win;
        bit [31:0] last_acked;
        bit        last_acked_ok;
        bit [31:0] timer_ms;
        bit        timer_on;
        bit [31:0] rto;
        bit [31:0] resends;
        bit [31:0] ent_seq[DEPTH];
        bit [31:0] ent_len[DEPTH];
        bit        ent_syn[DEPTH];
        bit        ent_fin[DEPTH];
        int        head;
        int        used;
        seg_res_t  batch[$];
        seg_res_t  expected_segs[$];
        int        errors;

        function new();
            iseq = 0; ito = 1000; msp = 1000; cap = 64000;
            buffered = 0; ended = 0; syn_sent = 0; fin_sent = 0;
            next_pos = 0; flight = 0; peer_win = 1; last_acked = 0; last_acked_ok = 0;
            timer_ms = 0; timer_on = 0; rto = 1000; resends = 0;
            head = 0; used = 0; errors = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, bit [31:0] v);
            case (idx)
                CFG_ISEQ: iseq = v;
                CFG_ITO: begin
                    ito = {16'd0, v[15:0]};
                    rto = ito;
                end
                CFG_MSP: msp = {21'd0, v[10:0]};
                CFG_CAP: cap = {16'd0, v[15:0]};
            endcase
        endfunction

        function void emit(bit s, bit [31:0] q, bit [31:0] l, bit sy, bit fi, bit rt);
            seg_res_t r;
            if (batch.size() >= MAX_RESULTS) return;
            r = '{default: 0};
            r.has_seg = s; r.seqno = q; r.payload = l[10:0];
            r.syn = sy; r.fin = fi; r.rtx = rt;
            batch.push_back(r);
        endfunction

        function void flight_add(bit [31:0] n);
            flight = (n > 32'h1FFFF - flight) ? 32'h1FFFF : flight + n;
        endfunction

        function void flight_sub(longint unsigned n);
            flight = (n >= flight) ? 0 : flight - n[31:0];
        endfunction

        function void push_seg(bit [31:0] q, bit [31:0] l, bit sy, bit fi);
            int t;
            if (used >= DEPTH) return;
            t = (head + used) % DEPTH;
            ent_seq[t] = q; ent_len[t] = l; ent_syn[t] = sy; ent_fin[t] = fi;
            used++;
        endfunction

        function void send_segments();
            bit [31:0] win, room, take, len, q;
            bit        fi;
            if (!syn_sent) begin
                q = iseq + next_pos;
                syn_sent = 1;
                next_pos += 1;
                flight_add(1);
                emit(1, q, 0, 1, 0, 0);
                push_seg(q, 0, 1, 0);
                timer_on = 1;
                return;
            end
            win = peer_win != 0 ? peer_win : 1;
            room = win > flight ? win - flight : 0;
            while (room > 0 && !fin_sent && batch.size() < MAX_RESULTS && used < DEPTH) begin
                q = iseq + next_pos;
                take = room < msp ? room : msp;
                if (take > buffered) take = buffered;
                buffered -= take;
                fi = 0;
                if (ended && buffered == 0 && room > take) begin
                    fi = 1;
                    fin_sent = 1;
                end
                len = take + fi;
                next_pos += len;
                flight_add(len);
                room -= len;
                if (len == 0) break;
                if (used == 0) timer_ms = 0;
                emit(1, q, take, 0, fi, 0);
                push_seg(q, take, 0, fi);
                timer_on = 1;
            end
            if (used == 0) begin
                timer_on = 0;
                timer_ms = 0;
            end
        endfunction

        function void take_ack(bit [31:0] ackno, bit [31:0] win);
            bit [31:0]       q, len, d;
            longint unsigned rem;
            bit              part;
            if (ackno > iseq + next_pos) return;
            if (last_acked_ok && ackno <= last_acked) begin
                peer_win = win;
                return;
            end
            while (used > 0) begin
                q = ent_seq[head];
                len = ent_len[head] + ent_syn[head] + ent_fin[head];
                if (!(q < ackno)) break;
                timer_ms = 0;
                rto = ito;
                if (!last_acked_ok || last_acked <= q) begin
                    d = ackno - q;
                    part = len > d;
                    if (part) begin
                        flight_sub(d);
                        last_acked = ackno;
                    end else begin
                        flight_sub(len);
                        last_acked = q + len;
                        head = (head + 1) % DEPTH;
                        used--;
                    end
                end else begin
                    rem = longint'(len) - longint'(last_acked - q);
                    d = ackno - last_acked;
                    part = rem > d;
                    if (part) begin
                        flight_sub(d);
                        last_acked = ackno;
                    end else begin
                        flight_sub(rem);
                        last_acked = q + len;
                        head = (head + 1) % DEPTH;
                        used--;
                    end
                end
                last_acked_ok = 1;
                if (part) break;
            end
            if (used == 0) timer_on = 0;
            resends = 0;
            peer_win = win;
            send_segments();
        endfunction

        function void take_tick(bit [31:0] ms);
            if (!timer_on) return;
            timer_ms = (ms > 32'hFFFFFFFF - timer_ms) ? 32'hFFFFFFFF : timer_ms + ms;
            if (used == 0 || timer_ms < rto) return;
            timer_ms = 0;
            emit(1, ent_seq[head], ent_len[head], ent_syn[head], ent_fin[head], 1);
            if (peer_win != 0) begin
                rto = (rto > 32'h7FFFFFFF) ? 32'hFFFFFFFF : rto * 2;
                if (resends < 32'hFFFF) resends++;
            end
        endfunction

        function void note_item(seg_req_t it);
            bit [31:0] acc, space;
            acc = 0;
            batch.delete();
            case (it.func)
                FN_WRITE: begin
                    if (!ended) begin
                        space = cap > buffered ? cap - buffered : 0;
                        acc = ({16'd0, it.byte_count} < space) ? {16'd0, it.byte_count}
                                                               : space;
                        buffered += acc;
                    end
                    if (it.end_input) ended = 1;
                end
                FN_ACK: take_ack(it.ack_number, {16'd0, it.adv_window});
                FN_TICK: take_tick({16'd0, it.elapsed_ms});
                FN_FILL: send_segments();
                FN_EMPTY: emit(1, iseq + next_pos, 0, 0, 0, 0);
                default: ;
            endcase
            if (batch.size() == 0) emit(0, 0, 0, 0, 0, 0);
            foreach (batch[k]) begin
                batch[k].accepted = acc[15:0];
                batch[k].in_flight = flight[16:0];
                batch[k].rtx_count = resends[15:0];
                batch[k].last = (k == batch.size() - 1);
                expected_segs.push_back(batch[k]);
            end
        endfunction

        function void check_result(seg_res_t got);
            seg_res_t e;
            if (expected_segs.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            e = expected_segs.pop_front();
            if (got != e) begin
                $display("%0t: mismatch expected %p", $time, e);
                $display("%0t:          actual   %p", $time, got);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [2:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    sender_scoreboard sb;
    int               cycles;
    int               burst_left;
    int               stall_mode;
    logic [15:0]      stall_pat;

    tcp_sender_retransmit_engine #(.OUTSTANDING_DEPTH(DEPTH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("tcp_sender_retransmit_engine test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        stall_pat <= {stall_pat[14:0],
                      stall_pat[15] ^ stall_pat[13] ^ stall_pat[12] ^ stall_pat[10]};
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= stall_pat[0] | stall_pat[3];
            default: m_tready <= stall_pat[0];
        endcase
    end

    always @(posedge aclk) begin
        seg_res_t r;
        if (aresetn && m_tvalid && m_tready) begin
            r.has_seg   = m_tdata[0];
            r.seqno     = m_tdata[32:1];
            r.payload   = m_tdata[43:33];
            r.syn       = m_tdata[44];
            r.fin       = m_tdata[45];
            r.rtx       = m_tdata[46];
            r.accepted  = m_tdata[62:47];
            r.in_flight = m_tdata[79:63];
            r.rtx_count = m_tdata[95:80];
            r.last      = m_tlast;
            sb.check_result(r);
        end
    end

    task automatic send_item(seg_req_t it);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= it.func;
        s_tdata  <= {7'd0, it.elapsed_ms, it.adv_window, it.ack_number, it.end_input,
                     it.byte_count};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(it);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_segs.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_regs(bit [31:0] iseq, bit [31:0] ito, bit [31:0] msp, bit [31:0] cap);
        bit [31:0] vals[4];
        vals = '{iseq, ito, msp, cap};
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= i[1:0];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            sb.set_reg(cfg_idx_t'(i), vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic seg_req_t noise_req(logic [2:0] f);
        seg_req_t it;
        it.func       = f;
        it.byte_count = 16'($urandom);
        it.end_input  = 1'b0;
        it.ack_number = $urandom;
        it.adv_window = 16'($urandom);
        it.elapsed_ms = 16'($urandom);
        return it;
    endfunction

    function automatic seg_req_t make_req(logic [2:0] f, int a, bit [31:0] b);
        seg_req_t it;
        it = noise_req(f);
        case (f)
            FN_WRITE: it.byte_count = 16'(a);
            FN_ACK: begin
                it.ack_number = b;
                it.adv_window = 16'(a);
            end
            FN_TICK: it.elapsed_ms = 16'(a);
            default: ;
        endcase
        return it;
    endfunction

    function automatic seg_req_t random_req(bit allow_end);
        seg_req_t  it;
        int        pick;
        bit [31:0] lo, hi;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            it = noise_req(FN_WRITE);
            case ($urandom_range(0, 5))
                0: it.byte_count = 0;
                1: it.byte_count = 16'hFFFF;
                2: it.byte_count = 16'($urandom_range(1, 3000));
                default: it.byte_count = 16'($urandom_range(1, 400));
            endcase
            it.end_input = allow_end && ($urandom_range(0, 29) == 0);
        end else if (pick < 55) begin
            it = noise_req(FN_ACK);
            lo = sb.last_acked_ok ? sb.last_acked - sb.iseq : 0;
            hi = sb.next_pos;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: it.ack_number = sb.iseq + hi;
                4, 5, 6: it.ack_number = sb.iseq + (hi >= lo ? lo + $urandom_range(0, hi - lo) : hi);
                7: it.ack_number = sb.iseq + hi + $urandom_range(1, 5);
                default: ;
            endcase
            case ($urandom_range(0, 7))
                0: it.adv_window = 0;
                1: it.adv_window = 16'hFFFF;
                2, 3: it.adv_window = 16'($urandom_range(1, 64));
                default: it.adv_window = 16'($urandom_range(1, 6000));
            endcase
        end else if (pick < 75) begin
            it = noise_req(FN_TICK);
            case ($urandom_range(0, 5))
                0: it.elapsed_ms = 16'hFFFF;
                1: it.elapsed_ms = 0;
                default: it.elapsed_ms = 16'($urandom_range(1, 800));
            endcase
        end else if (pick < 90) begin
            it = noise_req(FN_FILL);
        end else if (pick < 95) begin
            it = noise_req(FN_EMPTY);
        end else begin
            it = noise_req(3'($urandom_range(5, 7)));
        end
        return it;
    endfunction

    task automatic random_run(int n, bit allow_end);
        for (int i = 0; i < n; i++) begin
            send_item(random_req(allow_end));
            if (i == n / 2 && $urandom_range(0, 1) == 0) drain();
        end
    endtask

    initial begin
        sb         = new();
        cycles     = 0;
        burst_left = 0;
        stall_mode = 0;
        stall_pat  = 16'hACE1;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_wdata  = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_regs(32'd0, 32'd1000, 32'd1000, 32'd64000);
        send_item(noise_req(3'd5));
        send_item(noise_req(3'd6));
        send_item(noise_req(3'd7));
        send_item(noise_req(FN_EMPTY));
        send_item(make_req(FN_TICK, 16'hFFFF, 0));
        send_item(noise_req(FN_FILL));
        send_item(noise_req(FN_FILL));
        send_item(make_req(FN_WRITE, 0, 0));
        send_item(make_req(FN_WRITE, 16'hFFFF, 0));
        send_item(make_req(FN_TICK, 999, 0));
        send_item(make_req(FN_TICK, 16'hFFFF, 0));
        send_item(make_req(FN_ACK, 100, 32'd50));
        send_item(make_req(FN_ACK, 0, 32'd1));
        send_item(make_req(FN_TICK, 16'hFFFF, 0));
        send_item(make_req(FN_TICK, 16'hFFFF, 0));
        send_item(make_req(FN_ACK, 16'hFFFF, 32'd1));
        send_item(make_req(FN_ACK, 3000, 32'd500));
        send_item(make_req(FN_ACK, 3000, 32'd501));
        send_item(make_req(FN_ACK, 16'hFFFF, sb.iseq + sb.next_pos));
        send_item(noise_req(FN_FILL));
        drain();

        stall_mode = 1;
        write_regs(32'd0, 32'd1, 32'd1, 32'd1);
        random_run(60, 0);
        drain();

        stall_mode = 2;
        write_regs(32'hFFFFFFFF, 32'hFFFF, 32'd1460, 32'hFFFF);
        random_run(60, 0);
        drain();

        stall_mode = 0;
        write_regs($urandom, $urandom_range(1, 2000), $urandom_range(1, 1460),
                   $urandom_range(1, 65535));
        random_run(60, 0);
        drain();

        stall_mode = 1;
        write_regs(32'hFFFFF000, $urandom_range(50, 500), $urandom_range(100, 600),
                   $urandom_range(2000, 20000));
        random_run(70, 1);
        send_item(make_req(FN_WRITE, 500, 0));
        send_item(make_req(FN_ACK, 16'hFFFF, sb.iseq + sb.next_pos));
        begin
            seg_req_t it;
            it = make_req(FN_WRITE, 300, 0);
            it.end_input = 1'b1;
            send_item(it);
        end
        send_item(make_req(FN_ACK, 16'hFFFF, sb.iseq + sb.next_pos));
        send_item(make_req(FN_WRITE, 100, 0));
        send_item(noise_req(FN_FILL));
        send_item(make_req(FN_TICK, 16'hFFFF, 0));
        send_item(make_req(FN_ACK, 16'hFFFF, sb.iseq + sb.next_pos));
        drain();

        if (sb.errors == 0 && sb.expected_segs.size() == 0) begin
            $display("tcp_sender_retransmit_engine test passed");
        end else begin
            $display("tcp_sender_retransmit_engine test failed");
        end
        $finish;
    end

endmodule

/* tcp_sender_retransmit_engine.f */
rtl/tsre_pkg.sv
rtl/tsre_ram.sv
rtl/tcp_sender_retransmit_engine.sv
verif/tb_top.sv
